[design/whr_pkg.sv]
package whr_pkg;

   localparam int SPEED_CLASSES = 80;
   localparam int DIRECTIONS    = 16;
   localparam int COUNT_WIDTH   = 32;
   localparam int ROW_LEN       = DIRECTIONS + 1;
   localparam int BIN_TOTAL     = (SPEED_CLASSES + 1) * ROW_LEN;
   localparam int ADDR_W        = $clog2(BIN_TOTAL);
   localparam int DIR_IDX_W     = $clog2(DIRECTIONS);

   localparam int ACTION_W = 2;
   localparam int ENTRY_W  = 4;
   localparam int DIR_W    = 9;
   localparam int SPEED_W  = 10;
   localparam int ROW_W    = 7;
   localparam int COL_W    = 5;
   localparam int DCOUNT_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int OUT_W      = 32;

   localparam int FULL_CIRCLE = 360;
   // x / 5 == (x * 205) >> 10 for every 10-bit x
   localparam int CLASS_RECIP = 205;
   localparam int CLASS_SHIFT = 10;
   localparam int QUOT_W      = 8;
   localparam int PROD_W      = SPEED_W + QUOT_W;

   localparam logic [SPEED_W-1:0] LIMIT_RESET  = '0;
   localparam logic [DIR_W-1:0]   NODATA_RESET = 9'd511;
   localparam logic [DCOUNT_W-1:0] DCOUNT_RESET = 5'd16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD    = 2'd0,
      ACT_OBSERVE = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DET_LIMIT = 2'd0,
      CSR_NODATA    = 2'd1,
      CSR_DIR_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      SEL_BIN   = 3'd0,
      SEL_ROW   = 3'd1,
      SEL_COL   = 3'd2,
      SEL_READ  = 3'd3,
      SEL_CLEAR = 3'd4
   } addr_sel_type;

   typedef struct packed {
      logic         capture;
      logic         eval;
      logic         load_write;
      logic         calm_inc;
      logic         search_init;
      logic         search_step;
      logic         mem_rd;
      logic         mem_we;
      logic         clear_step;
      logic         count_load;
      logic         respond;
      addr_sel_type addr_sel;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       calm_cond;
      logic       read_ok;
      logic       search_last;
      logic       clear_last;
   } status_type;

   function automatic logic [ADDR_W-1:0] bin_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
      bin_addr = ADDR_W'(row) * ADDR_W'(ROW_LEN) + ADDR_W'(col);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] v);
      count_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
   endfunction

endpackage

[design/whr_ctrl.sv]
module whr_ctrl
   import whr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [12:0] {
      S_CLEAR     = 13'b0000000000001,
      S_IDLE      = 13'b0000000000010,
      S_EVAL      = 13'b0000000000100,
      S_SEARCH    = 13'b0000000001000,
      S_RD_BIN    = 13'b0000000010000,
      S_WR_BIN    = 13'b0000000100000,
      S_RD_ROW    = 13'b0000001000000,
      S_WR_ROW    = 13'b0000010000000,
      S_RD_COL    = 13'b0000100000000,
      S_WR_COL    = 13'b0001000000000,
      S_READ      = 13'b0010000000000,
      S_READ_WAIT = 13'b0100000000000,
      S_DONE      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.mem_we     = 1'b1;
            cmd.clear_step = 1'b1;
            cmd.addr_sel   = SEL_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            unique case (status.action)
               ACT_LOAD: begin
                  cmd.load_write = 1'b1;
                  state_in       = S_DONE;
               end
               ACT_OBSERVE: begin
                  if (status.calm_cond) begin
                     cmd.calm_inc = 1'b1;
                     state_in     = S_DONE;
                  end else begin
                     cmd.search_init = 1'b1;
                     state_in        = S_SEARCH;
                  end
               end
               ACT_READ: begin
                  state_in = status.read_ok ? S_READ : S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.search_last) state_in = S_RD_BIN;
         end
         S_RD_BIN: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = SEL_BIN;
            state_in     = S_WR_BIN;
         end
         S_WR_BIN: begin
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = SEL_BIN;
            state_in     = S_RD_ROW;
         end
         S_RD_ROW: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = SEL_ROW;
            state_in     = S_WR_ROW;
         end
         S_WR_ROW: begin
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = SEL_ROW;
            state_in     = S_RD_COL;
         end
         S_RD_COL: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = SEL_COL;
            state_in     = S_WR_COL;
         end
         S_WR_COL: begin
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = SEL_COL;
            state_in     = S_DONE;
         end
         S_READ: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = SEL_READ;
            state_in     = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            cmd.count_load = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[design/whr_datapath.sv]
module whr_datapath
   import whr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [ENTRY_W-1:0]     req_entry_index,
   input  logic [DIR_W-1:0]       req_direction,
   input  logic [SPEED_W-1:0]     req_speed,
   input  logic [ROW_W-1:0]       req_bin_row,
   input  logic [COL_W-1:0]       req_bin_column,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_valid,
   output logic [OUT_W-1:0]       rsp_count_value,
   output logic [OUT_W-1:0]       rsp_calm_total,
   output logic [ROW_W-1:0]       rsp_speed_class,
   output logic [COL_W-1:0]       rsp_direction_column,
   output logic                   rsp_calm,
   output logic                   rsp_speed_clipped
);

   // request capture
   action_type             action_ff;
   logic [ENTRY_W-1:0]     entry_ff;
   logic [DIR_W-1:0]       dir_ff;
   logic [SPEED_W-1:0]     speed_ff;
   logic [ROW_W-1:0]       row_ff;
   logic [COL_W-1:0]       col_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= action_type'(req_action);
         entry_ff  <= req_entry_index;
         dir_ff    <= req_direction;
         speed_ff  <= req_speed;
         row_ff    <= req_bin_row;
         col_ff    <= req_bin_column;
      end
   end

   // configuration registers
   logic [SPEED_W-1:0]  limit_ff;
   logic [DIR_W-1:0]    nodata_ff;
   logic [DCOUNT_W-1:0] dcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         nodata_ff <= NODATA_RESET;
         dcount_ff <= DCOUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DET_LIMIT: limit_ff  <= csr_data[SPEED_W-1:0];
            CSR_NODATA:    nodata_ff <= csr_data[DIR_W-1:0];
            CSR_DIR_COUNT: dcount_ff <= csr_data[DCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // classification
   logic                 calm_cond;
   logic [SPEED_W-1:0]   diff;
   logic [PROD_W-1:0]    prod;
   logic [QUOT_W-1:0]    quot;
   logic                 clip;
   logic [ROW_W-1:0]     cls;

   assign calm_cond = (dir_ff == nodata_ff) || (speed_ff < limit_ff);
   assign diff      = speed_ff - limit_ff;
   assign prod      = PROD_W'(diff) * PROD_W'(CLASS_RECIP);
   assign quot      = prod[CLASS_SHIFT +: QUOT_W];
   assign clip      = (quot > QUOT_W'(SPEED_CLASSES - 1));
   assign cls       = clip ? ROW_W'(SPEED_CLASSES - 1) : quot[ROW_W-1:0];

   logic             hit_ff;
   logic             calm_ff;
   logic             clip_ff;
   logic [ROW_W-1:0] cls_ff;
   logic             is_obs;

   assign is_obs = (action_ff == ACT_OBSERVE);

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         hit_ff  <= is_obs && !calm_cond;
         calm_ff <= is_obs && calm_cond;
         clip_ff <= is_obs && !calm_cond && clip;
         cls_ff  <= (is_obs && !calm_cond) ? cls : '0;
      end
   end

   // calm counter
   logic [COUNT_WIDTH-1:0] calm_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         calm_count_ff <= '0;
      end else if (cmd.calm_inc) begin
         calm_count_ff <= count_inc(calm_count_ff);
      end
   end

   // direction table
   logic [DIR_W-1:0] table_ff [DIRECTIONS];

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         table_ff[entry_ff[DIR_IDX_W-1:0]] <= dir_ff;
      end
   end

   // nearest sector search, one entry a cycle
   logic [DIR_IDX_W-1:0] idx_ff;
   logic [DIR_IDX_W-1:0] best_idx_ff;
   logic [DIR_W-1:0]     best_dist_ff;
   logic [DIR_W-1:0]     entry_dir;
   logic [DIR_W-1:0]     dist_a;
   logic [DIR_W-1:0]     dist_b;
   logic [DIR_W-1:0]     sector_gap;
   logic [DIR_IDX_W-1:0] idx_last;
   logic [COL_W-1:0]     column;

   assign entry_dir  = table_ff[idx_ff];
   assign dist_a     = (entry_dir >= dir_ff) ? entry_dir - dir_ff : dir_ff - entry_dir;
   assign dist_b     = (dist_a >= DIR_W'(FULL_CIRCLE)) ? dist_a - DIR_W'(FULL_CIRCLE)
                                                       : DIR_W'(FULL_CIRCLE) - dist_a;
   assign sector_gap = (dist_a < dist_b) ? dist_a : dist_b;

   always_comb begin
      if (dcount_ff == '0) begin
         idx_last = '0;
      end else if (dcount_ff > DCOUNT_W'(DIRECTIONS)) begin
         idx_last = DIR_IDX_W'(DIRECTIONS - 1);
      end else begin
         idx_last = DIR_IDX_W'(dcount_ff - DCOUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         idx_ff       <= '0;
         best_idx_ff  <= '0;
         best_dist_ff <= DIR_W'(FULL_CIRCLE);
      end else if (cmd.search_step) begin
         idx_ff <= idx_ff + DIR_IDX_W'(1);
         if (sector_gap < best_dist_ff) begin
            best_dist_ff <= sector_gap;
            best_idx_ff  <= idx_ff;
         end
      end
   end

   assign column = COL_W'(best_idx_ff) + COL_W'(1);

   // bin memory
   logic [COUNT_WIDTH-1:0] bin_mem_ff [BIN_TOTAL];
   logic [COUNT_WIDTH-1:0] bin_rdata_ff;
   logic [ADDR_W-1:0]      clear_cnt_ff;
   logic [ADDR_W-1:0]      addr;
   logic [COUNT_WIDTH-1:0] wdata;

   always_comb begin
      case (cmd.addr_sel)
         SEL_BIN:  addr = bin_addr(cls_ff, column);
         SEL_ROW:  addr = bin_addr(cls_ff, '0);
         SEL_COL:  addr = bin_addr(ROW_W'(SPEED_CLASSES), column);
         SEL_READ: addr = bin_addr(row_ff, col_ff);
         default:  addr = clear_cnt_ff;
      endcase
   end

   assign wdata = (cmd.addr_sel == SEL_CLEAR) ? '0 : count_inc(bin_rdata_ff);

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         bin_mem_ff[addr] <= wdata;
      end
      if (cmd.mem_rd) begin
         bin_rdata_ff <= bin_mem_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_cnt_ff <= clear_cnt_ff + ADDR_W'(1);
      end
   end

   // read result
   logic [COUNT_WIDTH-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         count_ff <= '0;
      end else if (cmd.count_load) begin
         count_ff <= bin_rdata_ff;
      end
   end

   // response register
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_count_ff;
   logic [ROW_W-1:0] rsp_class_ff;
   logic [COL_W-1:0] rsp_column_ff;
   logic             rsp_calm_ff;
   logic             rsp_clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_count_ff  <= OUT_W'(count_ff);
         rsp_class_ff  <= cls_ff;
         rsp_column_ff <= hit_ff ? column : '0;
         rsp_calm_ff   <= calm_ff;
         rsp_clip_ff   <= clip_ff;
      end
   end

   assign status.action      = action_ff;
   assign status.calm_cond   = calm_cond;
   assign status.read_ok     = (row_ff <= ROW_W'(SPEED_CLASSES)) &&
                               (col_ff <= COL_W'(DIRECTIONS));
   assign status.search_last = (idx_ff == idx_last);
   assign status.clear_last  = (clear_cnt_ff == ADDR_W'(BIN_TOTAL - 1));

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_count_value      = rsp_count_ff;
   assign rsp_calm_total       = OUT_W'(calm_count_ff);
   assign rsp_speed_class      = rsp_class_ff;
   assign rsp_direction_column = rsp_column_ff;
   assign rsp_calm             = rsp_calm_ff;
   assign rsp_speed_clipped    = rsp_clip_ff;

endmodule

[design/wind_rose_histogram.sv]
// channel   ports                              handshake
// request   req_* fields                       start & !busy
// response  rsp_* fields                       rsp_valid, one cycle
// config    csr_index, csr_data                csr_valid & csr_ready
//
// load, calm observation and out-of-range read skip the bin memory; a read
// reads one bin; a counted observation searches n sectors (1 to 16), one
// sector per cycle, then three read-modify-writes on the single-port bin memory
// after reset busy stays high while all 1377 bin entries clear, one entry a cycle
// responses cannot be stalled; csr writes are always ready
module wind_rose_histogram
   import whr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [ENTRY_W-1:0]    req_entry_index,
   input  logic [DIR_W-1:0]      req_direction,
   input  logic [SPEED_W-1:0]    req_speed,
   input  logic [ROW_W-1:0]      req_bin_row,
   input  logic [COL_W-1:0]      req_bin_column,
   output logic                  rsp_valid,
   output logic [OUT_W-1:0]      rsp_count_value,
   output logic [OUT_W-1:0]      rsp_calm_total,
   output logic [ROW_W-1:0]      rsp_speed_class,
   output logic [COL_W-1:0]      rsp_direction_column,
   output logic                  rsp_calm,
   output logic                  rsp_speed_clipped,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;
   logic       ctrl_busy;

   assign csr_ready = 1'b1;
   assign busy      = ctrl_busy;

   whr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (ctrl_busy)
   );

   whr_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_action           (req_action),
      .req_entry_index      (req_entry_index),
      .req_direction        (req_direction),
      .req_speed            (req_speed),
      .req_bin_row          (req_bin_row),
      .req_bin_column       (req_bin_column),
      .csr_write            (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_count_value      (rsp_count_value),
      .rsp_calm_total       (rsp_calm_total),
      .rsp_speed_class      (rsp_speed_class),
      .rsp_direction_column (rsp_direction_column),
      .rsp_calm             (rsp_calm),
      .rsp_speed_clipped    (rsp_speed_clipped)
   );

endmodule

[design/whr_checker.sv]
module whr_checker
   import whr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [ACTION_W-1:0]   req_action,
   input logic [ENTRY_W-1:0]    req_entry_index,
   input logic [DIR_W-1:0]      req_direction,
   input logic [SPEED_W-1:0]    req_speed,
   input logic [ROW_W-1:0]      req_bin_row,
   input logic [COL_W-1:0]      req_bin_column,
   input logic                  rsp_valid,
   input logic [OUT_W-1:0]      rsp_count_value,
   input logic [OUT_W-1:0]      rsp_calm_total,
   input logic [ROW_W-1:0]      rsp_speed_class,
   input logic [COL_W-1:0]      rsp_direction_column,
   input logic                  rsp_calm,
   input logic                  rsp_speed_clipped,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   // accepted request holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // one response per request, single-cycle strobe
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // calm observation carries no class or column
   a_calm_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_calm) |-> (rsp_speed_class == '0 && rsp_direction_column == '0))
      else $error("calm response with class or column");

   // clipped class sits at the last speed class
   a_clip_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_speed_clipped) |->
         (rsp_speed_class == ROW_W'(SPEED_CLASSES - 1) && !rsp_calm))
      else $error("clipped response with wrong class");

endmodule

bind wind_rose_histogram whr_checker u_whr_checker (.*);
